// ===== sv/segment_wedge_clip_defines.svh =====
// ----------------------------------------------------------------------------
// Segment wedge clip assertion macros
// Shared concurrent assertion forms, clocked on i_clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_WEDGE_CLIP_DEFINES_SVH
`define SEGMENT_WEDGE_CLIP_DEFINES_SVH

// Same-cycle implication.
`define SWC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swc_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment wedge clip package
// Widths, codes, pipeline record types and helpers shared by the block.
// ----------------------------------------------------------------------------
package swc_pkg;

    localparam int CW    = 16;          // coordinate width
    localparam int NW    = 16;          // edge normal register width
    localparam int PW    = CW + NW;     // one product a*x
    localparam int SW    = PW + 1;      // edge distance a*x + b*y
    localparam int MSW   = PW;          // magnitude of the start distance
    localparam int DENW  = SW;          // magnitude of the denominator
    localparam int DW    = CW;          // magnitude of an endpoint delta
    localparam int QW    = DW;          // quotient bits, one per divider cell
    localparam int NUMW  = DW + MSW;    // dividend width
    localparam int RW    = DENW;        // partial remainder width
    localparam int ADDRW = 4;
    localparam int DATAW = 32;

    typedef enum logic [1:0] {
        REG_LOW_A  = 2'd0,
        REG_LOW_B  = 2'd1,
        REG_HIGH_A = 2'd2,
        REG_HIGH_B = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_REJECT = 3'd0,
        ST_START  = 3'd1,
        ST_END    = 3'd2,
        ST_NONE   = 3'd3,
        ST_BOTH   = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
    } t_seg;

    typedef struct packed {
        t_seg seg;
        logic rej;
        logic ms;
        logic me;
    } t_item;

    typedef struct packed {
        t_item             item;
        logic              act;
        logic              move_end;
        logic              neg_x;
        logic              neg_y;
        logic [DENW-1:0]   den;
        logic [RW-1:0]     rem_x;
        logic [RW-1:0]     rem_y;
        logic [QW-1:0]     num_x;
        logic [QW-1:0]     num_y;
        logic [QW-1:0]     q_x;
        logic [QW-1:0]     q_y;
    } t_div;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] hi;
        logic signed [CW+1:0] lo;
        hi = (CW+2)'((1 <<< (CW-1)) - 1);
        lo = -(CW+2)'(1 <<< (CW-1));
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage

// ===== sv/swc_seg_if.sv =====
// ----------------------------------------------------------------------------
// Segment channel
// Valid/ready channel carrying one input segment.
// ----------------------------------------------------------------------------
interface swc_seg_if;
    import swc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;

    modport source(output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== sv/swc_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one clipped segment and its status.
// ----------------------------------------------------------------------------
interface swc_res_if;
    import swc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] clipped_start_x;
    logic signed [CW-1:0] clipped_start_y;
    logic signed [CW-1:0] clipped_end_x;
    logic signed [CW-1:0] clipped_end_y;
    logic [2:0]           clip_status;

    modport source(output valid, clipped_start_x, clipped_start_y, clipped_end_x,
                   clipped_end_y, clip_status, input ready);
    modport sink(input valid, clipped_start_x, clipped_start_y, clipped_end_x,
                 clipped_end_y, clip_status, output ready);
endinterface

// ===== sv/swc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for both coordinates, registered.
// ----------------------------------------------------------------------------
module swc_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  swc_pkg::t_div i_div,
    output logic          o_valid,
    output swc_pkg::t_div o_div
);
    import swc_pkg::*;

    logic          r_valid;
    t_div          r_div;
    t_div          n_div;
    logic [RW:0]   w_tx;
    logic [RW:0]   w_ty;
    logic          w_gx;
    logic          w_gy;

    always_comb begin
        n_div = i_div;
        w_tx  = {i_div.rem_x, i_div.num_x[QW-1]};
        w_ty  = {i_div.rem_y, i_div.num_y[QW-1]};
        w_gx  = w_tx >= {1'b0, i_div.den};
        w_gy  = w_ty >= {1'b0, i_div.den};
        n_div.rem_x = w_gx ? RW'(w_tx - {1'b0, i_div.den}) : w_tx[RW-1:0];
        n_div.rem_y = w_gy ? RW'(w_ty - {1'b0, i_div.den}) : w_ty[RW-1:0];
        n_div.num_x = {i_div.num_x[QW-2:0], 1'b0};
        n_div.num_y = {i_div.num_y[QW-2:0], 1'b0};
        n_div.q_x   = {i_div.q_x[QW-2:0], w_gx};
        n_div.q_y   = {i_div.q_y[QW-2:0], w_gy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
endmodule

// ===== sv/swc_edge.sv =====
// ----------------------------------------------------------------------------
// Edge clip stage
// Clips a segment against one half-plane through the origin: three front
// stages, a row of divider cells, and one stage that moves the endpoint.
// ----------------------------------------------------------------------------
module swc_edge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic signed [swc_pkg::NW-1:0] i_a,
    input  logic signed [swc_pkg::NW-1:0] i_b,
    input  logic                        i_valid,
    input  swc_pkg::t_item              i_item,
    output logic                        o_valid,
    output swc_pkg::t_item              o_item
);
    import swc_pkg::*;

    // Stage 1: products.
    logic                 r1_valid;
    t_item                r1_item;
    logic signed [PW-1:0] r1_pa0, r1_pb0, r1_pa1, r1_pb1;

    // Stage 2: side test and magnitudes.
    logic                 r2_valid;
    t_item                r2_item;
    logic                 r2_act, r2_move_end, r2_neg_x, r2_neg_y;
    logic [MSW-1:0]       r2_ms0;
    logic [DENW-1:0]      r2_den;
    logic [DW-1:0]        r2_mdx, r2_mdy;

    // Stage 3: dividends.
    logic                 r3_valid;
    t_div                 r3_div;

    logic signed [SW-1:0]   w_s0, w_s1;
    logic signed [SW:0]     w_den;
    logic signed [CW:0]     w_dx, w_dy;
    logic                   w_in0, w_in1;
    t_item                  w_item2;
    logic [NUMW-1:0]        w_px, w_py;

    logic [QW:0]            w_cv;
    t_div                   w_cd [QW+1];

    logic                   r_valid;
    t_item                  r_item;
    t_item                  n_item;
    logic signed [CW+1:0]   w_nx, w_ny;
    t_div                   w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_valid  <= w_cv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= i_item;
            r1_pa0  <= i_a * i_item.seg.x0;
            r1_pb0  <= i_b * i_item.seg.y0;
            r1_pa1  <= i_a * i_item.seg.x1;
            r1_pb1  <= i_b * i_item.seg.y1;
        end
    end

    always_comb begin
        w_s0  = SW'(r1_pa0) + SW'(r1_pb0);
        w_s1  = SW'(r1_pa1) + SW'(r1_pb1);
        w_den = (SW+1)'(w_s1) - (SW+1)'(w_s0);
        w_dx  = (CW+1)'(r1_item.seg.x1) - (CW+1)'(r1_item.seg.x0);
        w_dy  = (CW+1)'(r1_item.seg.y1) - (CW+1)'(r1_item.seg.y0);
        w_in0 = !w_s0[SW-1];
        w_in1 = !w_s1[SW-1];
        w_item2 = r1_item;
        if (!r1_item.rej && !w_in0 && !w_in1) begin
            w_item2.rej = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_item     <= w_item2;
            r2_act      <= !r1_item.rej && (w_in0 != w_in1);
            r2_move_end <= w_in0;
            // Sign of d * (-s0) / den; a zero operand yields a zero quotient anyway.
            r2_neg_x    <= w_dx[CW] ^ (w_in0 && (w_s0 != '0)) ^ w_den[SW];
            r2_neg_y    <= w_dy[CW] ^ (w_in0 && (w_s0 != '0)) ^ w_den[SW];
            r2_ms0      <= w_s0[SW-1] ? MSW'(-w_s0) : MSW'(w_s0);
            r2_den      <= w_den[SW] ? DENW'(-w_den) : DENW'(w_den);
            r2_mdx      <= w_dx[CW] ? DW'(-w_dx) : DW'(w_dx);
            r2_mdy      <= w_dy[CW] ? DW'(-w_dy) : DW'(w_dy);
        end
    end

    // |s0| <= |den|, so the quotient fits in QW bits and the upper dividend
    // bits already sit below the divisor.
    assign w_px = NUMW'(r2_mdx) * NUMW'(r2_ms0);
    assign w_py = NUMW'(r2_mdy) * NUMW'(r2_ms0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_div.item     <= r2_item;
            r3_div.act      <= r2_act;
            r3_div.move_end <= r2_move_end;
            r3_div.neg_x    <= r2_neg_x;
            r3_div.neg_y    <= r2_neg_y;
            r3_div.den      <= r2_den;
            r3_div.rem_x    <= RW'(w_px[NUMW-1:QW]);
            r3_div.rem_y    <= RW'(w_py[NUMW-1:QW]);
            r3_div.num_x    <= w_px[QW-1:0];
            r3_div.num_y    <= w_py[QW-1:0];
            r3_div.q_x      <= '0;
            r3_div.q_y      <= '0;
        end
    end

    assign w_cv[0] = r3_valid;
    assign w_cd[0] = r3_div;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        swc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_cv[k]),
            .i_div   (w_cd[k]),
            .o_valid (w_cv[k+1]),
            .o_div   (w_cd[k+1])
        );
    end

    assign w_last = w_cd[QW];

    always_comb begin
        w_nx = (CW+2)'(w_last.item.seg.x0)
             + (w_last.neg_x ? -(CW+2)'(w_last.q_x) : (CW+2)'(w_last.q_x));
        w_ny = (CW+2)'(w_last.item.seg.y0)
             + (w_last.neg_y ? -(CW+2)'(w_last.q_y) : (CW+2)'(w_last.q_y));
        n_item = w_last.item;
        if (w_last.act) begin
            if (w_last.move_end) begin
                n_item.seg.x1 = sat_coord(w_nx);
                n_item.seg.y1 = sat_coord(w_ny);
                n_item.me     = 1'b1;
            end else begin
                n_item.seg.x0 = sat_coord(w_nx);
                n_item.seg.y0 = sat_coord(w_ny);
                n_item.ms     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== sv/segment_wedge_clip.sv =====
// ----------------------------------------------------------------------------
// Segment wedge clip
// Clips a planar segment against both edges of a wedge with its apex at the
// origin.
// ----------------------------------------------------------------------------
// Usage: segments enter on i_seg and clipped segments leave on o_res, both
// valid/ready channels; a transfer happens when valid and ready are high.
// The edge normals are written through the APB port (4 registers, byte
// addresses 0, 4, 8, 12, 16 bits each), by the user only while no segment
// is in flight; the block does not enforce it. Each edge is one clip unit
// of 20 stages: products, side test, dividend multiply, 16 restoring divider
// cells (one quotient bit each) and the endpoint update. The two units run in
// series, low edge first, and feed the output register.
// Throughput is one segment per cycle while no result waits on a low
// o_res.ready; the divider cell row is fully pipelined.
// Reset clears all valid flags and the normals to zero, which makes both
// edges pass every segment untouched.
// While the receiver holds o_res.ready low with a result waiting, the
// whole pipeline freezes and i_seg.ready drops; bubbles are not squeezed out.
// ----------------------------------------------------------------------------
`include "segment_wedge_clip_defines.svh"

module segment_wedge_clip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    swc_seg_if.sink                       i_seg,
    swc_res_if.source                     o_res,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [swc_pkg::ADDRW-1:0]     i_paddr,
    input  logic [swc_pkg::DATAW-1:0]     i_pwdata,
    output logic [swc_pkg::DATAW-1:0]     o_prdata,
    output logic                          o_pready
);
    import swc_pkg::*;

    logic signed [NW-1:0] r_low_a, r_low_b, r_high_a, r_high_b;
    t_reg_idx             w_idx;
    logic                 w_wr;
    logic                 w_en;
    t_item                w_in_item;
    logic                 w_v0, w_v1;
    t_item                w_it0, w_it1;
    logic                 r_out_valid;
    t_item                r_out_item;
    t_status              w_status;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[ADDRW-1:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_a  <= '0;
            r_low_b  <= '0;
            r_high_a <= '0;
            r_high_b <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_LOW_A:  r_low_a  <= i_pwdata[NW-1:0];
                REG_LOW_B:  r_low_b  <= i_pwdata[NW-1:0];
                REG_HIGH_A: r_high_a <= i_pwdata[NW-1:0];
                REG_HIGH_B: r_high_b <= i_pwdata[NW-1:0];
                default:    r_low_a  <= r_low_a;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LOW_A:  o_prdata = DATAW'($unsigned(r_low_a));
            REG_LOW_B:  o_prdata = DATAW'($unsigned(r_low_b));
            REG_HIGH_A: o_prdata = DATAW'($unsigned(r_high_a));
            REG_HIGH_B: o_prdata = DATAW'($unsigned(r_high_b));
            default:    o_prdata = '0;
        endcase
    end

    assign w_en        = !r_out_valid || o_res.ready;
    assign i_seg.ready = w_en;

    always_comb begin
        w_in_item.seg.x0 = i_seg.start_x;
        w_in_item.seg.y0 = i_seg.start_y;
        w_in_item.seg.x1 = i_seg.end_x;
        w_in_item.seg.y1 = i_seg.end_y;
        w_in_item.rej    = 1'b0;
        w_in_item.ms     = 1'b0;
        w_in_item.me     = 1'b0;
    end

    swc_edge u_low (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_a     (r_low_a),
        .i_b     (r_low_b),
        .i_valid (i_seg.valid),
        .i_item  (w_in_item),
        .o_valid (w_v0),
        .o_item  (w_it0)
    );

    swc_edge u_high (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_a     (r_high_a),
        .i_b     (r_high_b),
        .i_valid (w_v0),
        .i_item  (w_it0),
        .o_valid (w_v1),
        .o_item  (w_it1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item <= w_it1;
        end
    end

    always_comb begin
        priority if (r_out_item.rej) begin
            w_status = ST_REJECT;
        end else if (r_out_item.ms && r_out_item.me) begin
            w_status = ST_BOTH;
        end else if (r_out_item.ms) begin
            w_status = ST_START;
        end else if (r_out_item.me) begin
            w_status = ST_END;
        end else begin
            w_status = ST_NONE;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.clipped_start_x = r_out_item.seg.x0;
    assign o_res.clipped_start_y = r_out_item.seg.y0;
    assign o_res.clipped_end_x   = r_out_item.seg.x1;
    assign o_res.clipped_end_y   = r_out_item.seg.y1;
    assign o_res.clip_status     = w_status;

    `SWC_ASSERT_IMPL(a_status_range, o_res.valid, o_res.clip_status <= ST_BOTH,
        "clip status out of range")
    `SWC_ASSERT_NEXT(a_last_stage_moves, w_v1 && w_en, o_res.valid,
        "result lost between last clip unit and output register")
    `SWC_ASSERT_NEXT(a_cfg_low_a, w_wr && (w_idx == REG_LOW_A),
        r_low_a == $past(i_pwdata[NW-1:0]), "lower edge register not written")
endmodule
